@@ hw/rtl/skf_pkg.sv @@
// shared types, keyframe tables and widths for the sun keyframe interpolator
package skf_pkg;

   // field widths
   localparam int TIME_W    = 16;
   localparam int MIX_W     = 17;
   localparam int SEG_W     = 3;
   localparam int RECIP_W   = 21;
   localparam int OUT_W     = 16;
   localparam int NUM_OUT   = 9;
   localparam int MAG_W     = 15;
   localparam int L2_W      = 30;
   localparam int ROOT_W    = 29;
   localparam int REM_W     = 32;
   localparam int DIVN_W    = 44;
   localparam int QUO_W     = 17;

   // pipeline depths
   localparam int SQRT_STEPS = 29;
   localparam int FRAC_PAIRS = 14;
   localparam int DIV_STEPS  = 17;
   localparam int FRONT_STAGES = 4;
   localparam int STAGES     = FRONT_STAGES + SQRT_STEPS + 1 + DIV_STEPS + 1;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // fixed-point constants
   localparam logic [MIX_W-1:0] MIX_ONE   = 17'd65536;
   localparam logic [QUO_W-1:0] DIR_ONE   = 17'd16384;
   localparam logic [35:0]      SUN_BIAS  = 36'd327680;
   localparam logic [36:0]      AMB_BIAS  = 37'd3276800;
   localparam logic [19:0]      DIV10_MUL = 20'd838861;
   localparam logic [19:0]      DIV100_MUL = 20'd671089;

   // keyframe times, Q0.16
   localparam logic [63:0] T0 = 64'd0;
   localparam logic [63:0] T1 = 64'd13653;
   localparam logic [63:0] T2 = 64'd16384;
   localparam logic [63:0] T3 = 64'd32768;
   localparam logic [63:0] T4 = 64'd46421;
   localparam logic [63:0] T5 = 64'd60074;
   localparam logic [63:0] T6 = 64'd62805;
   localparam logic [63:0] T7 = 64'd65536;
   localparam logic [63:0] TWO32 = 64'd4294967296;

   // segment reciprocals, round(2^32 / width)
   localparam logic [63:0] R0 = (TWO32 + (T1 - T0) / 2) / (T1 - T0);
   localparam logic [63:0] R1 = (TWO32 + (T2 - T1) / 2) / (T2 - T1);
   localparam logic [63:0] R2 = (TWO32 + (T3 - T2) / 2) / (T3 - T2);
   localparam logic [63:0] R3 = (TWO32 + (T4 - T3) / 2) / (T4 - T3);
   localparam logic [63:0] R4 = (TWO32 + (T5 - T4) / 2) / (T5 - T4);
   localparam logic [63:0] R5 = (TWO32 + (T6 - T5) / 2) / (T6 - T5);
   localparam logic [63:0] R6 = (TWO32 + (T7 - T6) / 2) / (T7 - T6);

   // item from front to back
   typedef struct packed {
      logic [SEG_W-1:0] seg;
      logic [MIX_W-1:0] mix;
   } fe_item_type;

   // result fields, dir_x in the lowest slot
   typedef logic [NUM_OUT-1:0][OUT_W-1:0] rsp_data_type;

   // side data carried along the normalize pipeline
   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic                  zero;
      logic [5:0][OUT_W-1:0] col;
   } carry_type;

   function automatic logic [16:0] kf_time(logic [SEG_W-1:0] idx);
      logic [16:0] t;
      begin
         case (idx)
            3'd0: t = T0[16:0];
            3'd1: t = T1[16:0];
            3'd2: t = T2[16:0];
            3'd3: t = T3[16:0];
            3'd4: t = T4[16:0];
            3'd5: t = T5[16:0];
            3'd6: t = T6[16:0];
            default: t = T7[16:0];
         endcase
         return t;
      end
   endfunction

   function automatic logic [RECIP_W-1:0] kf_recip(logic [SEG_W-1:0] idx);
      logic [RECIP_W-1:0] r;
      begin
         case (idx)
            3'd0: r = R0[RECIP_W-1:0];
            3'd1: r = R1[RECIP_W-1:0];
            3'd2: r = R2[RECIP_W-1:0];
            3'd3: r = R3[RECIP_W-1:0];
            3'd4: r = R4[RECIP_W-1:0];
            3'd5: r = R5[RECIP_W-1:0];
            default: r = R6[RECIP_W-1:0];
         endcase
         return r;
      end
   endfunction

   // direction rows, x in bits 15:0, Q1.14
   function automatic logic [47:0] kf_dir_row(logic [SEG_W-1:0] idx);
      logic [47:0] d;
      begin
         case (idx)
            3'd0: d = {16'sd0,     16'sd16384, 16'sd0};
            3'd1: d = {16'sd0,     16'sd16384, -16'sd4915};
            3'd2: d = {-16'sd16384, 16'sd0,    16'sd0};
            3'd3: d = {16'sd0,     16'sd16384, 16'sd0};
            3'd4: d = {16'sd8192,  16'sd16384, 16'sd0};
            3'd5: d = {16'sd16384, 16'sd0,     16'sd0};
            3'd6: d = {16'sd4915,  16'sd16384, 16'sd0};
            default: d = {16'sd0,  16'sd16384, 16'sd0};
         endcase
         return d;
      end
   endfunction

   // color rows, red in bits 15:0, Q8.8
   function automatic logic [47:0] kf_color_row(logic [SEG_W-1:0] idx);
      logic [47:0] c;
      begin
         case (idx)
            3'd0: c = {16'd45696, 16'd44083, 16'd41216};
            3'd1: c = {16'd57344, 16'd55296, 16'd51712};
            3'd2: c = {16'd41728, 16'd54784, 16'd65280};
            3'd3: c = {16'd65280, 16'd65280, 16'd65280};
            3'd4: c = {16'd47104, 16'd60672, 16'd65280};
            3'd5: c = {16'd42240, 16'd54784, 16'd64000};
            3'd6: c = {16'd32640, 16'd31488, 16'd29440};
            default: c = {16'd45696, 16'd44083, 16'd41216};
         endcase
         return c;
      end
   endfunction

endpackage

@@ hw/rtl/skf_front.sv @@
// front part: segment search and mix factor
module skf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [15:0]           in_time,
   output logic                  out_valid,
   input  logic                  out_ready,
   output skf_pkg::fe_item_type  out_item
);

   logic                         vld_ff;
   skf_pkg::fe_item_type         item_ff;
   logic [skf_pkg::SEG_W-1:0]    seg_in;
   logic [16:0]                  off_in;
   logic [39:0]                  prod_in;
   logic [39:0]                  mix_raw;
   logic [skf_pkg::MIX_W-1:0]    mix_in;

   assign in_ready  = !vld_ff || out_ready;
   assign out_valid = vld_ff;
   assign out_item  = item_ff;

   // last keyframe not after the input
   always_comb begin
      seg_in = '0;
      for (int i = 1; i < 7; i++) begin
         if ({1'b0, in_time} >= skf_pkg::kf_time(3'(i))) begin
            seg_in = 3'(i);
         end
      end
   end

   // offset times segment reciprocal, rounded and saturated
   always_comb begin
      off_in  = {1'b0, in_time} - skf_pkg::kf_time(seg_in);
      prod_in = 40'(off_in) * 40'(skf_pkg::kf_recip(seg_in));
      mix_raw = (prod_in + 40'd32768) >> 16;
      if (mix_raw > 40'(skf_pkg::MIX_ONE)) begin
         mix_in = skf_pkg::MIX_ONE;
      end else begin
         mix_in = mix_raw[skf_pkg::MIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         item_ff.seg <= seg_in;
         item_ff.mix <= mix_in;
      end
   end

endmodule

@@ hw/rtl/skf_queue.sv @@
// short queue between front and back
module skf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  skf_pkg::fe_item_type  in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output skf_pkg::fe_item_type  out_item
);

   skf_pkg::fe_item_type             mem_ff [skf_pkg::QUEUE_DEPTH];
   logic [skf_pkg::QPTR_W-1:0]       wr_ptr_ff;
   logic [skf_pkg::QPTR_W-1:0]       rd_ptr_ff;
   logic [skf_pkg::QCNT_W-1:0]       cnt_ff;
   logic                             push;
   logic                             pop;

   assign in_ready  = cnt_ff != skf_pkg::QCNT_W'(skf_pkg::QUEUE_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

@@ hw/rtl/skf_back.sv @@
// back part: blend, color scaling, square root and normalize pipeline
module skf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  skf_pkg::fe_item_type  in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output skf_pkg::rsp_data_type out_data
);

   localparam int NS = skf_pkg::STAGES;
   localparam int SW = skf_pkg::SQRT_STEPS;
   localparam int DW = skf_pkg::DIV_STEPS;

   logic [NS-1:0]                vld_ff;
   logic                         adv;

   // blend stage
   logic signed [33:0]           dnum_ff [3];
   logic [32:0]                  cnum_ff [3];
   // rounding stage
   logic [skf_pkg::MAG_W-1:0]    qmag_ff [3];
   logic [2:0]                   qneg_ff;
   logic [18:0]                  tsun_ff [3];
   logic [19:0]                  tamb_ff [3];
   // square stage
   logic [skf_pkg::L2_W-1:0]     sq_ff [3];
   skf_pkg::carry_type           sqc_ff;
   // sum stage
   logic [skf_pkg::L2_W-1:0]     l2_ff;
   skf_pkg::carry_type           l2c_ff;
   // square root steps
   logic [skf_pkg::ROOT_W-1:0]   root_ff [SW];
   logic [skf_pkg::REM_W-1:0]    srem_ff [SW];
   logic [skf_pkg::L2_W-1:0]     sl2_ff  [SW];
   skf_pkg::carry_type           sc_ff   [SW];
   // division setup
   logic [skf_pkg::ROOT_W-1:0]   plen_ff;
   logic [skf_pkg::DIVN_W-1:0]   pnum_ff [3];
   skf_pkg::carry_type           pc_ff;
   // division steps
   logic [skf_pkg::ROOT_W-1:0]   dlen_ff [DW];
   logic [skf_pkg::DIVN_W-1:0]   drem_ff [DW][3];
   logic [skf_pkg::QUO_W-1:0]    dquo_ff [DW][3];
   skf_pkg::carry_type           dc_ff   [DW];
   // output register
   skf_pkg::rsp_data_type        out_ff;

   logic [47:0]                  dra;
   logic [47:0]                  drb;
   logic [47:0]                  cra;
   logic [47:0]                  crb;
   logic [skf_pkg::MIX_W-1:0]    w0;
   logic signed [17:0]           w0_s;
   logic signed [17:0]           m_s;

   assign adv       = !vld_ff[NS-1] || out_ready;
   assign in_ready  = adv;
   assign out_valid = vld_ff[NS-1];
   assign out_data  = out_ff;

   // valid chain, whole pipeline advances together
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-2:0], in_valid};
      end
   end

   // keyframe rows for the segment and the next one
   always_comb begin
      dra  = skf_pkg::kf_dir_row(in_item.seg);
      drb  = skf_pkg::kf_dir_row(in_item.seg + 1'b1);
      cra  = skf_pkg::kf_color_row(in_item.seg);
      crb  = skf_pkg::kf_color_row(in_item.seg + 1'b1);
      w0   = skf_pkg::MIX_ONE - in_item.mix;
      w0_s = $signed({1'b0, w0});
      m_s  = $signed({1'b0, in_item.mix});
   end

   // linear blend of direction and color
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            dnum_ff[i] <= 34'($signed(dra[i*16 +: 16]) * w0_s)
                        + 34'($signed(drb[i*16 +: 16]) * m_s);
            cnum_ff[i] <= 33'(cra[i*16 +: 16] * w0) + 33'(crb[i*16 +: 16] * in_item.mix);
         end
      end
   end

   // round direction, scale color ahead of the reciprocal multiply
   always_ff @(posedge clock) begin
      logic [33:0] ab;
      logic [33:0] rnd;
      logic [35:0] ts;
      logic [36:0] ta;
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            ab  = dnum_ff[i][33] ? 34'(-dnum_ff[i]) : 34'(dnum_ff[i]);
            rnd = ab + 34'd32768;
            qmag_ff[i] <= rnd[30:16];
            qneg_ff[i] <= dnum_ff[i][33];
            ts  = 36'(cnum_ff[i]) * 36'd6 + skf_pkg::SUN_BIAS;
            ta  = 37'(cnum_ff[i]) * 37'd12 + skf_pkg::AMB_BIAS;
            tsun_ff[i] <= ts[34:16];
            tamb_ff[i] <= ta[35:16];
         end
      end
   end

   // squares, color divide by 10 and 100 through reciprocals
   always_ff @(posedge clock) begin
      logic [38:0] ps;
      logic [39:0] pa;
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= 30'(qmag_ff[i] * qmag_ff[i]);
            sqc_ff.mag[i] <= qmag_ff[i];
            ps = 39'(tsun_ff[i]) * 39'(skf_pkg::DIV10_MUL);
            pa = 40'(tamb_ff[i]) * 40'(skf_pkg::DIV100_MUL);
            sqc_ff.col[i]     <= ps[38:23];
            sqc_ff.col[3 + i] <= 16'(pa[39:26]);
         end
         sqc_ff.neg  <= qneg_ff;
         sqc_ff.zero <= 1'b0;
      end
   end

   // squared length
   always_ff @(posedge clock) begin
      logic [skf_pkg::L2_W-1:0] s;
      skf_pkg::carry_type       c;
      if (adv) begin
         s      = sq_ff[0] + sq_ff[1] + sq_ff[2];
         c      = sqc_ff;
         c.zero = s == '0;
         l2_ff  <= s;
         l2c_ff <= c;
      end
   end

   // square root of l2 * 2^28, two radicand bits per step
   for (genvar k = 0; k < SW; k++) begin : g_sqrt
      localparam int P = SW - 1 - k;
      logic [1:0]                    pair;
      logic [skf_pkg::ROOT_W-1:0]    root_prev;
      logic [skf_pkg::REM_W-1:0]     rem_prev;
      logic [skf_pkg::L2_W-1:0]      l2_prev;
      skf_pkg::carry_type            c_prev;
      logic [33:0]                   rem2;
      logic [33:0]                   trial;

      if (k == 0) begin : g_first
         assign root_prev = '0;
         assign rem_prev  = '0;
         assign l2_prev   = l2_ff;
         assign c_prev    = l2c_ff;
      end else begin : g_next
         assign root_prev = root_ff[k-1];
         assign rem_prev  = srem_ff[k-1];
         assign l2_prev   = sl2_ff[k-1];
         assign c_prev    = sc_ff[k-1];
      end

      if (P >= skf_pkg::FRAC_PAIRS) begin : g_data
         assign pair = l2_prev[2*(P-skf_pkg::FRAC_PAIRS) +: 2];
      end else begin : g_zero
         assign pair = 2'b00;
      end

      assign rem2  = {rem_prev, pair};
      assign trial = 34'({root_prev, 2'b01});

      always_ff @(posedge clock) begin
         if (adv) begin
            if (rem2 >= trial) begin
               srem_ff[k] <= 32'(rem2 - trial);
               root_ff[k] <= {root_prev[skf_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               srem_ff[k] <= rem2[31:0];
               root_ff[k] <= {root_prev[skf_pkg::ROOT_W-2:0], 1'b0};
            end
            sl2_ff[k] <= l2_prev;
            sc_ff[k]  <= c_prev;
         end
      end
   end

   // dividend with half the divisor added for rounding
   always_ff @(posedge clock) begin
      if (adv) begin
         plen_ff <= root_ff[SW-1];
         pc_ff   <= sc_ff[SW-1];
         for (int i = 0; i < 3; i++) begin
            pnum_ff[i] <= (44'(sc_ff[SW-1].mag[i]) << 28) + 44'(root_ff[SW-1] >> 1);
         end
      end
   end

   // restoring division, one quotient bit per step
   for (genvar d = 0; d < DW; d++) begin : g_div
      localparam int J = DW - 1 - d;
      logic [skf_pkg::ROOT_W-1:0]   len_prev;
      logic [skf_pkg::DIVN_W-1:0]   rem_prev [3];
      logic [skf_pkg::QUO_W-1:0]    quo_prev [3];
      skf_pkg::carry_type           c_prev;
      logic [45:0]                  dv;

      if (d == 0) begin : g_first
         assign len_prev = plen_ff;
         assign c_prev   = pc_ff;
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign rem_prev[i] = pnum_ff[i];
            assign quo_prev[i] = '0;
         end
      end else begin : g_next
         assign len_prev = dlen_ff[d-1];
         assign c_prev   = dc_ff[d-1];
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign rem_prev[i] = drem_ff[d-1][i];
            assign quo_prev[i] = dquo_ff[d-1][i];
         end
      end

      assign dv = 46'(len_prev) << J;

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int i = 0; i < 3; i++) begin
               if (46'(rem_prev[i]) >= dv) begin
                  drem_ff[d][i] <= 44'(46'(rem_prev[i]) - dv);
                  dquo_ff[d][i] <= quo_prev[i] | (17'd1 << J);
               end else begin
                  drem_ff[d][i] <= rem_prev[i];
                  dquo_ff[d][i] <= quo_prev[i];
               end
            end
            dlen_ff[d] <= len_prev;
            dc_ff[d]   <= c_prev;
         end
      end
   end

   // saturate, apply sign, pack result
   always_ff @(posedge clock) begin
      logic [skf_pkg::QUO_W-1:0] r;
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            r = dquo_ff[DW-1][i];
            if (r > skf_pkg::DIR_ONE) begin
               r = skf_pkg::DIR_ONE;
            end
            if (dc_ff[DW-1].zero) begin
               out_ff[i] <= '0;
            end else if (dc_ff[DW-1].neg[i]) begin
               out_ff[i] <= 16'(-r);
            end else begin
               out_ff[i] <= 16'(r);
            end
         end
         for (int i = 0; i < 6; i++) begin
            out_ff[3 + i] <= dc_ff[DW-1].col[i];
         end
      end
   end

endmodule

@@ hw/rtl/sun_keyframe_interpolator.sv @@
// top level of the sun keyframe interpolator
//
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tdata: time_of_day
// rsp      out  rsp_tvalid/rsp_tready  tdata: dir xyz, sun rgb, amb rgb
//
// one item per cycle sustained while rsp_tready stays high; the path from the accepting
// edge to rsp_tvalid runs through the front register, the queue, then 52 back stages
// (29 square root steps and 17 division steps set most of them).
// reset clears valid state only; the pipeline is empty after reset.
// a stalled result freezes the back pipeline; the queue lets the front go on
// taking items until it fills.
module sun_keyframe_interpolator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // time_of_day
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata    // dir_x, dir_y, dir_z, sun_red, sun_green,
                                     // sun_blue, amb_red, amb_green, amb_blue
);

   logic                  fe_valid;
   logic                  fe_ready;
   skf_pkg::fe_item_type  fe_item;
   logic                  q_valid;
   logic                  q_ready;
   skf_pkg::fe_item_type  q_item;
   skf_pkg::rsp_data_type be_data;

   // classify time into segment and mix
   skf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_time   (req_tdata),
      .out_valid (fe_valid),
      .out_ready (fe_ready),
      .out_item  (fe_item)
   );

   // decoupling queue
   skf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_ready  (fe_ready),
      .in_item   (fe_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   // blend and normalize
   skf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_item   (q_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (be_data)
   );

   assign rsp_tdata = be_data;

endmodule

@@ tb/sun_keyframe_interpolator_tb.sv @@
// testbench for the sun keyframe interpolator: directed table plus random times
`timescale 1ns / 1ps

module sun_keyframe_interpolator_tb;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [15:0]  req_tdata;    // time_of_day
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [143:0] rsp_tdata;    // dir_x, dir_y, dir_z, sun_red, sun_green,
                               // sun_blue, amb_red, amb_green, amb_blue

   sun_keyframe_interpolator u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   localparam int N_DIRECTED = 20;
   localparam int N_RANDOM   = 400;
   localparam int HOLD_CYCLES = 200;

   // lighting result for one time of day
   typedef struct {
      logic [15:0] lane [9];
   } light_type;

   light_type   light_q[$];
   int          mismatches;
   bit          calm;        // no idling in the last part of the run
   bit          hold_done;
   bit          sending_done;

   // directed times, with a few expected results typed in
   logic [15:0] dir_time [N_DIRECTED];
   bit          dir_has [N_DIRECTED];
   logic [143:0] dir_val [N_DIRECTED];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // keyframe tables
   function automatic longint kf_t(int i);
      longint t [8] = '{0, 13653, 16384, 32768, 46421, 60074, 62805, 65536};
      return t[i];
   endfunction

   function automatic longint kf_d(int i, int c);
      longint d [8][3] = '{'{0, 16384, 0}, '{-4915, 16384, 0}, '{0, 0, -16384},
         '{0, 16384, 0}, '{0, 16384, 8192}, '{0, 0, 16384}, '{0, 16384, 4915},
         '{0, 16384, 0}};
      return d[i][c];
   endfunction

   function automatic longint kf_c(int i, int c);
      longint k [8][3] = '{'{41216, 44083, 45696}, '{51712, 55296, 57344},
         '{65280, 54784, 41728}, '{65280, 65280, 65280}, '{65280, 60672, 47104},
         '{64000, 54784, 42240}, '{29440, 31488, 32640}, '{41216, 44083, 45696}};
      return k[i][c];
   endfunction

   function automatic longint qround(longint p);
      if (p >= 0) return (p + 32768) >>> 16;
      return -((-p + 32768) >>> 16);
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // sun lighting for one time of day
   function automatic light_type sun_light(logic [15:0] tod);
      light_type r;
      int seg;
      longint x, w, rc, m, w0, num, l2, len, mag, quo;
      longint q [3];
      x = tod;
      seg = 0;
      for (int i = 1; i < 7; i++) if (kf_t(i) <= x) seg = i;
      w = kf_t(seg + 1) - kf_t(seg);
      rc = (64'd4294967296 + w / 2) / w;
      m = ((x - kf_t(seg)) * rc + 32768) >>> 16;
      if (m > 65536) m = 65536;
      w0 = 65536 - m;
      l2 = 0;
      for (int i = 0; i < 3; i++) begin
         q[i] = qround(kf_d(seg, i) * w0 + kf_d(seg + 1, i) * m);
         l2 += q[i] * q[i];
      end
      if (l2 == 0) begin
         for (int i = 0; i < 3; i++) r.lane[i] = '0;
      end else begin
         len = int_sqrt(l2 << 28);
         for (int i = 0; i < 3; i++) begin
            mag = (q[i] < 0 ? -q[i] : q[i]) << 28;
            quo = (mag + len / 2) / len;
            if (quo > 16384) quo = 16384;
            r.lane[i] = 16'(q[i] < 0 ? -quo : quo);
         end
      end
      for (int i = 0; i < 3; i++) begin
         num = kf_c(seg, i) * w0 + kf_c(seg + 1, i) * m;
         r.lane[3 + i] = 16'((num * 6 + 327680) / 655360);
         r.lane[6 + i] = 16'((num * 12 + 3276800) / 6553600);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int idx, logic [15:0] got,
                                  logic [15:0] want);
      $display("mismatch %s lane %0d: got %h want %h", what, idx, got, want);
      mismatches++;
   endtask

   // directed table: midnight, keyframe edges, the top of the range and three mid-segment times
   initial begin
      logic [15:0] t [N_DIRECTED] = '{16'd0, 16'd1, 16'd13652, 16'd13653, 16'd13654,
         16'd16383, 16'd16384, 16'd32767, 16'd32768, 16'd46420, 16'd46421, 16'd60073,
         16'd60074, 16'd62804, 16'd62805, 16'd65534, 16'd65535, 16'h5555, 16'hAAAA,
         16'd24576};
      for (int i = 0; i < N_DIRECTED; i++) begin
         dir_time[i] = t[i];
         dir_has[i] = 1'b0;
      end
      // midnight: straight up, sun 0.6 of the Q8.8 color, amb 0.12 of it
      dir_has[0] = 1'b1;
      dir_val[0] = {16'd5484, 16'd5290, 16'd4946, 16'd27418, 16'd26450, 16'd24730,
                    16'd0, 16'd16384, 16'd0};
      // midday: straight up, full color 65280
      dir_has[8] = 1'b1;
      dir_val[8] = {16'd7834, 16'd7834, 16'd7834, 16'd39168, 16'd39168, 16'd39168,
                    16'd0, 16'd16384, 16'd0};
   end

   // sender
   task automatic send_time(logic [15:0] tod, bit has_fixed, logic [143:0] fixed);
      light_type e;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= tod;
      e = sun_light(tod);
      if (has_fixed) for (int i = 0; i < 9; i++) e.lane[i] = fixed[16*i +: 16];
      do @(posedge clock); while (!req_tready);
      light_q.insert(light_q.size(), e);
   endtask

   initial begin
      logic [15:0] tod;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      mismatches = 0;
      calm = 1'b0;
      sending_done = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < N_DIRECTED; i++) send_time(dir_time[i], dir_has[i], dir_val[i]);
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM * 3 / 4) calm = 1'b1;
         case ($urandom_range(0, 3))
            0: tod = 16'(kf_t($urandom_range(1, 6)) + $urandom_range(0, 4) - 2);
            default: tod = 16'($urandom);
         endcase
         send_time(tod, 1'b0, '0);
      end
      req_tvalid <= 1'b0;
      sending_done = 1'b1;
   end

   // receiver, with one long hold-off early on to back the block up
   initial begin
      int n;
      rsp_tready = 1'b0;
      hold_done = 1'b0;
      n = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!hold_done && n == 30) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         n++;
      end
   end

   // checker
   always @(posedge clock) begin
      light_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (light_q.size() == 0) begin
            report_mismatch("unexpected result", 0, rsp_tdata[15:0], 16'hxxxx);
         end else begin
            e = light_q.pop_front();
            for (int i = 0; i < 9; i++)
               if (rsp_tdata[16*i +: 16] !== e.lane[i])
                  report_mismatch("light", i, rsp_tdata[16*i +: 16], e.lane[i]);
         end
      end
   end

   // end of run
   initial begin
      wait (sending_done);
      wait (light_q.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && light_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/skf_pkg.sv
hw/rtl/skf_front.sv
hw/rtl/skf_queue.sv
hw/rtl/skf_back.sv
hw/rtl/sun_keyframe_interpolator.sv
tb/sun_keyframe_interpolator_tb.sv
